/* rtl/pcov_pkg.sv */
package pcov_pkg;

  localparam int unsigned SqSteps  = 32;
  localparam int unsigned DivSteps = 16;

  localparam logic [15:0] EpsReset = 16'd66;
  localparam logic [16:0] OneQ15   = 17'd32768;

  localparam logic signed [28:0] SatMax = 29'sd8388607;
  localparam logic signed [28:0] SatMin = -29'sd8388608;

  typedef struct packed {
    logic                    op;
    logic [2:0][15:0]        n;
    logic [2:0]              neg;
    logic [2:0][30:0]        mag;
    logic                    zero;
  } item_t;

  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0]      len;
    logic [2:0][46:0] rem;
    logic [2:0][15:0] q;
  } dv_t;

  typedef struct packed {
    logic [23:0] xx;
    logic [23:0] xy;
    logic [23:0] xz;
    logic [23:0] yy;
    logic [23:0] yz;
    logic [23:0] zz;
  } res_t;

endpackage

/* rtl/plane_covariance_from_normal.sv */
// Channel  Direction  Handshake                     Word
// in       input      in_valid_i / in_stall_o       operation, normal_x, normal_y, normal_z
// out      output     out_valid_o / out_stall_i     entry_xx .. entry_zz
// cfg      input      cfg_valid_i / cfg_ready_o     epsilon
//
// One word enters per cycle while in_stall_o is low; words leave in the order they came.
// The pipeline holds the 32-step square root and the 16-step dividers.
// Reset clears all valid bits and loads the default epsilon.
// A skid register behind the output lets the pipeline finish one word while the
// output is stalled; in_stall_o is high while that skid register is occupied.
module plane_covariance_from_normal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] entry_xx_o,
  output logic signed [23:0] entry_xy_o,
  output logic signed [23:0] entry_xz_o,
  output logic signed [23:0] entry_yy_o,
  output logic signed [23:0] entry_yz_o,
  output logic signed [23:0] entry_zz_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_epsilon_i
);
  import pcov_pkg::*;

  logic [15:0] eps_q;
  logic        en;
  logic        skid_valid_q;
  res_t        skid_q;
  logic        out_valid_q;
  res_t        out_q;

  // Front stages.
  logic        s1_valid_q, s2_valid_q, s3_valid_q;
  item_t       s1_q, s1_d, s2_q, s3_q;
  logic [2:0][61:0] s2_sq_q;
  logic [63:0] s3_l2_q;

  // Square root and divider chains.
  logic        sqv_q [SqSteps];
  item_t       sqi_q [SqSteps];
  sq_t         sqs_q [SqSteps];
  sq_t         sq_in [SqSteps];
  logic        sqv_in [SqSteps];
  item_t       sqi_in [SqSteps];

  logic        dvv_q [DivSteps];
  item_t       dvi_q [DivSteps];
  dv_t         dvs_q [DivSteps];
  dv_t         dv_in [DivSteps];
  logic        dvv_in [DivSteps];
  item_t       dvi_in [DivSteps];

  // Back stages.
  logic                    y_valid_q, c_valid_q, p_valid_q, d_valid_q;
  logic                    y_op_q, c_op_q, p_op_q;
  logic signed [2:0][15:0] y_n_q, y_y_q, c_n_q, c_y_q;
  logic signed [2:0][17:0] c_r_q;
  logic signed [2:0][5:0][35:0] p_q;
  logic signed [2:0][5:0][53:0] d_q;
  res_t                    res_d;

  function automatic sq_t sq_step(sq_t s);
    logic [35:0] r2;
    logic [35:0] t;
    sq_t         o;
    r2 = {s.rem[33:0], s.x[63:62]};
    t  = {2'b00, s.root, 2'b01};
    o.x = {s.x[61:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [17:0] rnd14(logic signed [32:0] a);
    logic [32:0] m;
    logic [32:0] t;
    m = a[32] ? 33'(-a) : 33'(a);
    t = (m + 33'd8192) >> 14;
    return a[32] ? -$signed(t[17:0]) : $signed(t[17:0]);
  endfunction

  function automatic logic [23:0] rnd27_sat(logic signed [55:0] a);
    logic [55:0]        m;
    logic [55:0]        t;
    logic signed [28:0] r;
    m = a[55] ? 56'(-a) : 56'(a);
    t = (m + 56'd67108864) >> 27;
    r = a[55] ? -$signed(t[28:0]) : $signed(t[28:0]);
    if (r > SatMax) begin
      r = SatMax;
    end else if (r < SatMin) begin
      r = SatMin;
    end
    return r[23:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_valid_q;
  assign in_stall_o  = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_epsilon_i;
    end
  end

  // Stage 1: the unnormalized second row.
  always_comb begin
    logic signed [32:0] v [3];
    v[0] = -33'(normal_y_i * normal_x_i);
    v[1] = 33'sd268435456 - 33'(normal_y_i * normal_y_i);
    v[2] = -33'(normal_y_i * normal_z_i);
    s1_d.op   = operation_i;
    s1_d.n    = {normal_z_i, normal_y_i, normal_x_i};
    for (int i = 0; i < 3; i++) begin
      s1_d.neg[i] = v[i][32];
      s1_d.mag[i] = v[i][32] ? 31'(-v[i]) : 31'(v[i]);
    end
    s1_d.zero = (s1_d.mag == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= 62'(s1_q.mag[i] * s1_q.mag[i]);
      end
      s3_q         <= s2_q;
      s3_l2_q      <= 64'(s2_sq_q[0]) + 64'(s2_sq_q[1]) + 64'(s2_sq_q[2]);
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    if (k == 0) begin : g_first
      assign sqv_in[k] = s3_valid_q;
      assign sqi_in[k] = s3_q;
      assign sq_in[k]  = '{x: s3_l2_q, rem: '0, root: '0};
    end else begin : g_next
      assign sqv_in[k] = sqv_q[k-1];
      assign sqi_in[k] = sqi_q[k-1];
      assign sq_in[k]  = sqs_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k] <= 1'b0;
      end else if (en) begin
        sqv_q[k] <= sqv_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqi_q[k] <= sqi_in[k];
        sqs_q[k] <= sq_step(sq_in[k]);
      end
    end
  end

  // Rounded division of each magnitude by the length, one quotient bit per stage.
  for (genvar j = 0; j < DivSteps; j++) begin : g_dv
    localparam int unsigned B = DivSteps - 1 - j;
    dv_t dv_d;

    if (j == 0) begin : g_first
      assign dvv_in[j] = sqv_q[SqSteps-1];
      assign dvi_in[j] = sqi_q[SqSteps-1];
      always_comb begin
        dv_in[j].len = sqs_q[SqSteps-1].root;
        dv_in[j].q   = '0;
        for (int c = 0; c < 3; c++) begin
          dv_in[j].rem[c] = {1'b0, sqi_q[SqSteps-1].mag[c], 15'd0}
                          + {15'd0, sqs_q[SqSteps-1].root};
        end
      end
    end else begin : g_next
      assign dvv_in[j] = dvv_q[j-1];
      assign dvi_in[j] = dvi_q[j-1];
      assign dv_in[j]  = dvs_q[j-1];
    end

    always_comb begin
      logic [48:0] rx;
      logic [48:0] t;
      dv_d.len = dv_in[j].len;
      t = {16'd0, dv_in[j].len, 1'b0} << B;
      for (int c = 0; c < 3; c++) begin
        rx = {2'b00, dv_in[j].rem[c]};
        if (rx >= t) begin
          dv_d.rem[c] = 47'(rx - t);
          dv_d.q[c]   = {dv_in[j].q[c][14:0], 1'b1};
        end else begin
          dv_d.rem[c] = dv_in[j].rem[c];
          dv_d.q[c]   = {dv_in[j].q[c][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[j] <= 1'b0;
      end else if (en) begin
        dvv_q[j] <= dvv_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dvi_q[j] <= dvi_in[j];
        dvs_q[j] <= dv_d;
      end
    end
  end

  // Back end: signed second row, first row, pair products, weights, sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en) begin
      y_valid_q <= dvv_q[DivSteps-1];
      c_valid_q <= y_valid_q;
      p_valid_q <= c_valid_q;
      d_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [17:0] rw [3][3];
    logic [16:0]        dw [3];
    if (en) begin
      y_op_q <= dvi_q[DivSteps-1].op;
      y_n_q  <= dvi_q[DivSteps-1].n;
      for (int c = 0; c < 3; c++) begin
        if (dvi_q[DivSteps-1].zero) begin
          y_y_q[c] <= '0;
        end else if (dvi_q[DivSteps-1].neg[c]) begin
          y_y_q[c] <= -$signed(dvs_q[DivSteps-1].q[c]);
        end else begin
          y_y_q[c] <= $signed(dvs_q[DivSteps-1].q[c]);
        end
      end

      c_op_q   <= y_op_q;
      c_n_q    <= y_n_q;
      c_y_q    <= y_y_q;
      c_r_q[0] <= rnd14(33'($signed(y_n_q[1]) * $signed(y_y_q[2]))
                      - 33'($signed(y_n_q[2]) * $signed(y_y_q[1])));
      c_r_q[1] <= rnd14(33'($signed(y_n_q[2]) * $signed(y_y_q[0]))
                      - 33'($signed(y_n_q[0]) * $signed(y_y_q[2])));
      c_r_q[2] <= rnd14(33'($signed(y_n_q[0]) * $signed(y_y_q[1]))
                      - 33'($signed(y_n_q[1]) * $signed(y_y_q[0])));

      for (int c = 0; c < 3; c++) begin
        rw[0][c] = c_r_q[c];
        rw[1][c] = 18'($signed(c_y_q[c]));
        rw[2][c] = 18'($signed(c_n_q[c]));
      end
      p_op_q <= c_op_q;
      for (int k = 0; k < 3; k++) begin
        p_q[k][0] <= rw[k][0] * rw[k][0];
        p_q[k][1] <= rw[k][0] * rw[k][1];
        p_q[k][2] <= rw[k][0] * rw[k][2];
        p_q[k][3] <= rw[k][1] * rw[k][1];
        p_q[k][4] <= rw[k][1] * rw[k][2];
        p_q[k][5] <= rw[k][2] * rw[k][2];
      end

      dw[0] = p_op_q ? {1'b0, eps_q} : OneQ15;
      dw[1] = dw[0];
      dw[2] = p_op_q ? OneQ15 : {1'b0, eps_q};
      for (int k = 0; k < 3; k++) begin
        for (int e = 0; e < 6; e++) begin
          d_q[k][e] <= 54'($signed(p_q[k][e]) * $signed({1'b0, dw[k]}));
        end
      end
    end
  end

  always_comb begin
    logic [23:0] r [6];
    for (int e = 0; e < 6; e++) begin
      r[e] = rnd27_sat(56'($signed(d_q[0][e])) + 56'($signed(d_q[1][e]))
                     + 56'($signed(d_q[2][e])));
    end
    res_d = '{xx: r[0], xy: r[1], xz: r[2], yy: r[3], yz: r[4], zz: r[5]};
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || (en && d_valid_q);
      skid_valid_q <= 1'b0;
    end else if (en && d_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (en && d_valid_q) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_xx_o  = out_q.xx;
  assign entry_xy_o  = out_q.xy;
  assign entry_xz_o  = out_q.xz;
  assign entry_yy_o  = out_q.yy;
  assign entry_yz_o  = out_q.yz;
  assign entry_zz_o  = out_q.zz;

endmodule
